// ===== sv/renc_pkg.sv =====
// Shared types and constants for the rotary encoder wrap counter.
// No dependencies; imported by every module of the block.
package renc_pkg;

  localparam int VALUE_W = 16;

  typedef logic [VALUE_W-1:0] value_t;

  // Pending turn codes
  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_RIGHT = 2'd1,
    TURN_LEFT  = 2'd2
  } turn_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_MIN_VALUE = 1'b0,
    CFG_MAX_VALUE = 1'b1
  } cfg_reg_t;

  // Level history patterns, oldest pair in the top bits
  localparam logic [7:0] PATTERN_RIGHT = 8'hE1;
  localparam logic [7:0] PATTERN_LEFT  = 8'hD2;

  typedef struct packed {
    logic   pin_a;
    logic   pin_b;
    logic   apply_turn;
    logic   load_enable;
    value_t load_value;
  } in_item_t;

  typedef struct packed {
    value_t      value_out;
    logic [1:0]  turn_pending;
  } out_item_t;

  typedef struct packed {
    value_t min_value;
    value_t max_value;
  } bounds_t;

endpackage

// ===== sv/renc_history.sv =====
// Level history and pending turn tracking for the rotary encoder wrap counter.
// Depends on renc_pkg.
module renc_history
  import renc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  acc,
  input  logic  pin_a,
  input  logic  pin_b,
  input  logic  apply_turn,
  output turn_t pend_new,
  output turn_t pend_nxt
);

  logic [7:0] hist_r;
  logic [7:0] hist_nxt;
  turn_t      pend_r;
  logic [1:0] pair;

  assign pair = {pin_b, pin_a};

  always_comb begin
    hist_nxt = hist_r;
    pend_new = pend_r;
    if (pair != hist_r[1:0]) begin
      hist_nxt = {hist_r[5:0], pair};
      if (hist_nxt == PATTERN_RIGHT) begin
        pend_new = TURN_RIGHT;
      end
      if (hist_nxt == PATTERN_LEFT) begin
        pend_new = TURN_LEFT;
      end
    end
    // apply consumes whatever turn is pending
    pend_nxt = apply_turn ? TURN_NONE : pend_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      pend_r <= TURN_NONE;
    end else if (acc) begin
      hist_r <= hist_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

// ===== sv/renc_value.sv =====
// Edited value register with load and wrapping increment/decrement.
// Depends on renc_pkg.
module renc_value
  import renc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    acc,
  input  logic    load_enable,
  input  value_t  load_value,
  input  logic    apply_turn,
  input  turn_t   pend_new,
  input  bounds_t bounds,
  output value_t  value_nxt
);

  value_t value_r;
  value_t base;

  always_comb begin
    base      = load_enable ? load_value : value_r;
    value_nxt = base;
    if (apply_turn) begin
      case (pend_new)
        TURN_RIGHT: value_nxt = (base < bounds.max_value) ? base + 16'd1 : bounds.min_value;
        TURN_LEFT:  value_nxt = (base > bounds.min_value) ? base - 16'd1 : bounds.max_value;
        default:    value_nxt = base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else if (acc) begin
      value_r <= value_nxt;
    end
  end

endmodule

// ===== sv/renc_out_buf.sv =====
// Two-entry result buffer (output register plus skid stage).
// Depends on renc_pkg.
module renc_out_buf
  import renc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      out_v_r;
  out_item_t out_d_r;
  logic      skid_v_r;
  out_item_t skid_d_r;
  logic      pop;

  assign pop       = out_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_item  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        // drain the skid stage first; no push is taken while it is full
        if (pop) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end
      end else if (push) begin
        if (out_v_r && !pop) begin
          skid_v_r <= 1'b1;
        end else begin
          out_v_r <= 1'b1;
        end
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_d_r <= skid_d_r;
      end
    end else if (push) begin
      if (out_v_r && !pop) begin
        skid_d_r <= push_item;
      end else begin
        out_d_r <= push_item;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid holds an item while output is empty");
  a_push_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !skid_v_r) |=> out_v_r) else $error("pushed item lost");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !pop) |=> skid_v_r && $stable(skid_d_r))
    else $error("skid item changed while held");
`endif

endmodule

// ===== sv/rotary_encoder_wrap_counter_core.sv =====
// Top level of the rotary encoder wrap counter: ports, config registers, glue.
// Depends on renc_pkg, renc_history, renc_value and renc_out_buf.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in      | input     | in_valid/in_stall  | in_item  (pins, apply, load)
//   out     | output    | out_valid/out_stall| out_item (value, pending turn)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while in_stall is low; its result is registered into the output register, or into
// the skid stage while the output is stalled. The item's whole update (history shift, pattern match, load,
// wrap add) is one combinational pass from the state registers to the state and output registers.
// Synchronous active-low reset clears state, bounds (min 0, max 0xFFFF) and valids.
// in_stall rises only while both the output register and its skid stage are full.
// cfg_ready is always high; write config only while the block is idle.
module rotary_encoder_wrap_counter_core
  import renc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  // item input
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  // result output
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  // configuration writes
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_reg_t  cfg_index,
  input  value_t    cfg_data
);

  logic      acc;
  logic      buf_full;
  bounds_t   bounds_r;
  turn_t     pend_new;
  turn_t     pend_nxt;
  value_t    value_nxt;
  out_item_t res;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign acc       = in_valid && !in_stall;

  // Hold the bounds; writes should land only while idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.min_value <= '0;
      bounds_r.max_value <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_VALUE: bounds_r.min_value <= cfg_data;
        CFG_MAX_VALUE: bounds_r.max_value <= cfg_data;
        default:       bounds_r <= bounds_r;
      endcase
    end
  end

  // Shift pin levels into the history and latch the pending turn
  renc_history u_history (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .pin_a      (in_item.pin_a),
    .pin_b      (in_item.pin_b),
    .apply_turn (in_item.apply_turn),
    .pend_new   (pend_new),
    .pend_nxt   (pend_nxt)
  );

  // Load, then apply the pending turn with wrap between the bounds
  renc_value u_value (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .load_enable (in_item.load_enable),
    .load_value  (in_item.load_value),
    .apply_turn  (in_item.apply_turn),
    .pend_new    (pend_new),
    .bounds      (bounds_r),
    .value_nxt   (value_nxt)
  );

  assign res.value_out    = value_nxt;
  assign res.turn_pending = pend_nxt;

  // Result register with a skid stage that takes one more result while the output is stalled
  renc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_item (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
